// ===== hdl/brle_pkg.sv =====
// Shared types and constants for the byte run-length text encoder.
// No dependencies; all hdl/ files but brle_checker refer to it by scoped names.
package brle_pkg;

  // Most result bytes one input transaction can produce, and the flush part of that.
  localparam int unsigned BurstMax = 6;
  localparam int unsigned FlushMax = 5;

  // Character codes used by the encoder.
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

  // Largest usable threshold; larger register values act as this one.
  localparam logic [2:0] THRESH_MAX = 3'd5;

  // Decimal cap on the repeat counter, so a bracketed count has at most three digits.
  localparam int unsigned DecCap = 999;

  // Configuration register indexes.
  localparam logic CFG_COMPRESS = 1'b0;
  localparam logic CFG_THRESH   = 1'b1;

  // Result bytes of one input transaction, ready to be drained in order.
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [2:0]               count;
  } burst_t;

endpackage

// ===== hdl/brle_front.sv =====
// Run state, configuration registers and burst composition for the encoder.
// Depends on brle_pkg; feeds brle_drain with one burst per accepted transaction.
module brle_front #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                in_fire_i,
  input  logic [7:0]          text_byte_i,
  input  logic                line_end_i,
  output brle_pkg::burst_t    burst_o
);

  // Saturation value of the repeat counter, split into decimal digits at elaboration.
  localparam int unsigned CapRaw = (1 << COUNT_BITS) - 1;
  localparam int unsigned Cap    = (CapRaw < brle_pkg::DecCap) ? CapRaw : brle_pkg::DecCap;
  localparam logic [3:0]  CapH   = 4'(Cap / 100);
  localparam logic [3:0]  CapT   = 4'((Cap / 10) % 10);
  localparam logic [3:0]  CapO   = 4'(Cap % 10);

  localparam int unsigned FlushLen = brle_pkg::FlushMax;

  logic       compress_q, compress_d;
  logic [2:0] thresh_q, thresh_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic [3:0] cnt_h_q, cnt_h_d;
  logic [3:0] cnt_t_q, cnt_t_d;
  logic [3:0] cnt_o_q, cnt_o_d;

  logic       same_byte;
  logic       count_only;
  logic       flush_en;
  logic       at_cap;
  logic [2:0] thresh_eff;
  logic       bracket;
  logic [FlushLen-1:0][7:0] flush_bytes;
  logic [2:0] flush_n;
  logic [7:0] tail_byte;

  // Configuration registers, to be written only while the block is idle; the block does not enforce it.
  always_comb begin
    compress_d = compress_q;
    thresh_d   = thresh_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brle_pkg::CFG_COMPRESS: compress_d = cfg_wdata_i[0];
        brle_pkg::CFG_THRESH:   thresh_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming transaction against the open run.
  assign same_byte  = held_valid_q && (text_byte_i == held_byte_q);
  assign count_only = !line_end_i && compress_q && same_byte;
  assign flush_en   = held_valid_q && ({cnt_h_q, cnt_t_q, cnt_o_q} != 12'd0);
  assign at_cap     = (cnt_h_q == CapH) && (cnt_t_q == CapT) && (cnt_o_q == CapO);
  assign thresh_eff = (thresh_q > brle_pkg::THRESH_MAX) ? brle_pkg::THRESH_MAX : thresh_q;
  assign bracket    = (cnt_h_q != 4'd0) || (cnt_t_q != 4'd0) || (cnt_o_q > 4'(thresh_eff));
  assign tail_byte  = line_end_i ? brle_pkg::CHAR_NEWLINE : text_byte_i;

  // Bytes that close the open run: a bracketed decimal count or plain repeats.
  always_comb begin
    for (int i = 0; i < FlushLen; i++) begin
      flush_bytes[i] = held_byte_q;
    end
    flush_n = 3'd0;
    if (flush_en) begin
      if (bracket) begin
        flush_bytes[0] = brle_pkg::CHAR_LBRACK;
        if (cnt_h_q != 4'd0) begin
          flush_bytes[1] = {brle_pkg::CHAR_DIGIT_HI, cnt_h_q};
          flush_bytes[2] = {brle_pkg::CHAR_DIGIT_HI, cnt_t_q};
          flush_bytes[3] = {brle_pkg::CHAR_DIGIT_HI, cnt_o_q};
          flush_bytes[4] = brle_pkg::CHAR_RBRACK;
          flush_n        = 3'd5;
        end else if (cnt_t_q != 4'd0) begin
          flush_bytes[1] = {brle_pkg::CHAR_DIGIT_HI, cnt_t_q};
          flush_bytes[2] = {brle_pkg::CHAR_DIGIT_HI, cnt_o_q};
          flush_bytes[3] = brle_pkg::CHAR_RBRACK;
          flush_n        = 3'd4;
        end else begin
          flush_bytes[1] = {brle_pkg::CHAR_DIGIT_HI, cnt_o_q};
          flush_bytes[2] = brle_pkg::CHAR_RBRACK;
          flush_n        = 3'd3;
        end
      end else begin
        // At or below the threshold the count is a single digit of at most five.
        flush_n = cnt_o_q[2:0];
      end
    end
  end

  // Burst: flush bytes first, then the literal or newline; empty if the item only extends a run.
  always_comb begin
    for (int i = 0; i < brle_pkg::BurstMax; i++) begin
      if (3'(i) < flush_n) begin
        burst_o.bytes[i] = flush_bytes[(i < FlushLen) ? i : FlushLen - 1];
      end else begin
        burst_o.bytes[i] = tail_byte;
      end
    end
    burst_o.count = count_only ? 3'd0 : flush_n + 3'd1;
  end

  // Run state update on each accepted transaction.
  always_comb begin
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    cnt_h_d      = cnt_h_q;
    cnt_t_d      = cnt_t_q;
    cnt_o_d      = cnt_o_q;
    if (in_fire_i) begin
      if (line_end_i || !compress_q) begin
        held_valid_d = 1'b0;
        cnt_h_d      = 4'd0;
        cnt_t_d      = 4'd0;
        cnt_o_d      = 4'd0;
      end else if (same_byte) begin
        // Decimal increment that stops at the cap.
        if (!at_cap) begin
          if (cnt_o_q != 4'd9) begin
            cnt_o_d = cnt_o_q + 4'd1;
          end else begin
            cnt_o_d = 4'd0;
            if (cnt_t_q != 4'd9) begin
              cnt_t_d = cnt_t_q + 4'd1;
            end else begin
              cnt_t_d = 4'd0;
              cnt_h_d = cnt_h_q + 4'd1;
            end
          end
        end
      end else begin
        held_byte_d  = text_byte_i;
        held_valid_d = 1'b1;
        cnt_h_d      = 4'd0;
        cnt_t_d      = 4'd0;
        cnt_o_d      = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compress_q   <= 1'b0;
      thresh_q     <= brle_pkg::THRESH_MAX;
      held_byte_q  <= 8'd0;
      held_valid_q <= 1'b0;
      cnt_h_q      <= 4'd0;
      cnt_t_q      <= 4'd0;
      cnt_o_q      <= 4'd0;
    end else begin
      compress_q   <= compress_d;
      thresh_q     <= thresh_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      cnt_h_q      <= cnt_h_d;
      cnt_t_q      <= cnt_t_d;
      cnt_o_q      <= cnt_o_d;
    end
  end

endmodule

// ===== hdl/brle_drain.sv =====
// Burst buffer and output register: sends one result byte per unstalled cycle.
// Depends on brle_pkg; loaded by the top level from brle_front.
module brle_drain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  brle_pkg::burst_t burst_i,
  output logic             take_ok_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  localparam int unsigned Depth = brle_pkg::BurstMax;

  logic [Depth-1:0][7:0] buf_q, buf_d;
  logic [2:0]            remain_q, remain_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;
  logic                  emit;

  // The output register can take a byte when empty or when its byte leaves now.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = out_free && (remain_q != 3'd0);
  assign take_ok_o = (remain_q == 3'd0) || ((remain_q == 3'd1) && out_free);

  // Buffer: load a new burst, or shift the head byte out toward the output register.
  always_comb begin
    buf_d    = buf_q;
    remain_d = remain_q;
    if (load_i) begin
      buf_d    = burst_i.bytes;
      remain_d = burst_i.count;
    end else if (emit) begin
      for (int i = 0; i < Depth - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      remain_d = remain_q - 3'd1;
    end
  end

  // Output register; the final byte of a burst carries the last flag.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = buf_q[0];
      out_last_d  = (remain_q == 3'd1);
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q    <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== hdl/byte_run_length_text_encoder_top.sv =====
// Top level of the byte run-length text encoder.
// Depends on brle_pkg, brle_front and brle_drain.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    text_byte_i, line_end_i
//   out      output     out_valid_o / out_stall_i  out_byte_o, last_of_run_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// An input transaction produces zero to six result bytes, sent one per unstalled cycle.
// The first result goes through the drain buffer, then the output register; the drain
// buffer sets the rate: it stalls the input until an item's last result leaves it.
// Items that only extend a run produce none and are taken every cycle the buffer is empty.
// Reset is asynchronous and active low; the block takes input right after release.
module byte_run_length_text_encoder_top #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  brle_pkg::burst_t burst;
  logic             take_ok;
  logic             in_fire;

  // A transaction is taken once the drain buffer can hold its burst.
  assign in_stall_o = !take_ok;
  assign in_fire    = in_valid_i && take_ok;

  brle_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .text_byte_i (text_byte_i),
    .line_end_i  (line_end_i),
    .burst_o     (burst)
  );

  brle_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_fire),
    .burst_i       (burst),
    .take_ok_o     (take_ok),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hdl/brle_checker.sv =====
// Port-level checks for the byte run-length text encoder.
// Depends only on the top level's ports; bound to byte_run_length_text_encoder_top below.
module brle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))
  else $error("stalled result changed");

  // Bytes of one burst leave without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o && !out_stall_i |=> out_valid_o)
  else $error("gap inside a burst");

  // Input is held off only while bytes wait, so an empty output fills next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> out_valid_o)
  else $error("input stalled with nothing to send");

  // Right after reset release the block is empty and ready.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
  else $error("not idle after reset");

endmodule

bind byte_run_length_text_encoder_top brle_checker u_brle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
